// ===== hw/rtl/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and constants of the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned KindWidth  = 6;
  localparam int unsigned RegWidth   = 5;

  // Special halt word, checked ahead of normal decoding
  localparam logic [InstrWidth-1:0] HaltWord  = 32'h0FF0_0513;
  localparam logic [InstrWidth-1:0] UpperMask = 32'hFFFF_F000;
  localparam logic [6:0]            Funct7Alt = 7'b0100000;
  localparam logic [6:0]            Funct7Zero = 7'b0000000;

  // Major opcodes
  localparam logic [6:0] OpR      = 7'b0110011;
  localparam logic [6:0] OpImm    = 7'b0010011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpLui    = 7'b0110111;
  localparam logic [6:0] OpSystem = 7'b1110011;

  // Instruction kind codes as seen on the result port
  typedef enum logic [KindWidth-1:0] {
    KIND_UNKNOWN = 6'd0,
    KIND_ADD     = 6'd1,
    KIND_SUB     = 6'd2,
    KIND_AND     = 6'd3,
    KIND_OR      = 6'd4,
    KIND_XOR     = 6'd5,
    KIND_SLL     = 6'd6,
    KIND_SRL     = 6'd7,
    KIND_SRA     = 6'd8,
    KIND_SLT     = 6'd9,
    KIND_SLTU    = 6'd10,
    KIND_ADDI    = 6'd11,
    KIND_ANDI    = 6'd12,
    KIND_ORI     = 6'd13,
    KIND_XORI    = 6'd14,
    KIND_SLLI    = 6'd15,
    KIND_SRLI    = 6'd16,
    KIND_SRAI    = 6'd17,
    KIND_SLTI    = 6'd18,
    KIND_SLTIU   = 6'd19,
    KIND_LB      = 6'd20,
    KIND_LBU     = 6'd21,
    KIND_LH      = 6'd22,
    KIND_LHU     = 6'd23,
    KIND_LW      = 6'd24,
    KIND_SB      = 6'd25,
    KIND_SH      = 6'd26,
    KIND_SW      = 6'd27,
    KIND_BEQ     = 6'd28,
    KIND_BGE     = 6'd29,
    KIND_BGEU    = 6'd30,
    KIND_BLT     = 6'd31,
    KIND_BLTU    = 6'd32,
    KIND_BNE     = 6'd33,
    KIND_JAL     = 6'd34,
    KIND_JALR    = 6'd35,
    KIND_AUIPC   = 6'd36,
    KIND_LUI     = 6'd37,
    KIND_ECALL   = 6'd38,
    KIND_EBREAK  = 6'd39,
    KIND_HALT    = 6'd40
  } instr_kind_e;

  // One decoded instruction
  typedef struct packed {
    instr_kind_e                 kind;
    logic [RegWidth-1:0]         rd;
    logic [RegWidth-1:0]         rs1;
    logic [RegWidth-1:0]         rs2;
    logic signed [InstrWidth-1:0] imm;
  } decode_t;

endpackage

// ===== hw/rtl/rv32i_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// Registered RV32I decoder: instruction word in, kind/registers/immediate out.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive instruction_word_i and raise start_i; a transaction
//   is taken at every rising edge with start_i high and busy_o low. busy_o is
//   always low, so a new word may be issued in every cycle.
//   Result channel: valid_o marks one decoded transaction for exactly one
//   cycle, together with instr_kind_o, dest_reg_o, src1_reg_o, src2_reg_o and
//   immediate_o. The receiver cannot stall; it must take the result then.
//   Path: an accepted word passes through the input register, the decode
//   logic and the result register before it reaches the result channel.
//   Throughput: 1 instruction per cycle; set by the single decode stage
//   between the input and result registers.
//   Reset: rst_ni (asynchronous, active low) clears the valid flags of both
//   registers; no transaction is in flight afterwards. Illegal encodings give
//   kind 0 with all other fields zero.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder import rvdec_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [InstrWidth-1:0]        instruction_word_i,
  output logic                         valid_o,
  output logic [KindWidth-1:0]         instr_kind_o,
  output logic [RegWidth-1:0]          dest_reg_o,
  output logic [RegWidth-1:0]          src1_reg_o,
  output logic [RegWidth-1:0]          src2_reg_o,
  output logic signed [InstrWidth-1:0] immediate_o
);

  logic                  in_valid_q;
  logic [InstrWidth-1:0] instr_q;
  logic                  out_valid_q;
  decode_t               dec_d;
  decode_t               dec_q;
  logic                  accept;

  // Never stalls: one transaction per cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instruction_word_i;
    end
  end

  // Decode stage
  rvdec_decode u_decode (
    .instr_i (instr_q),
    .dec_o   (dec_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o      = out_valid_q;
  assign instr_kind_o = dec_q.kind;
  assign dest_reg_o   = dec_q.rd;
  assign src1_reg_o   = dec_q.rs1;
  assign src2_reg_o   = dec_q.rs2;
  assign immediate_o  = dec_q.imm;

  // Unknown, halt and system results carry all-zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (instr_kind_o == KIND_UNKNOWN || instr_kind_o == KIND_HALT ||
                instr_kind_o == KIND_ECALL || instr_kind_o == KIND_EBREAK)
    |-> (dest_reg_o == '0 && src1_reg_o == '0 && src2_reg_o == '0 &&
         immediate_o == '0))
    else $error("non-zero fields on unknown/halt/system result");

  // A result appears only where a word was decoded in the prior cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_valid_q))
    else $error("result strobe without a decoded transaction");

  // Stores and branches never write a destination register
  a_no_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && instr_kind_o >= KIND_SB && instr_kind_o <= KIND_BNE
    |-> dest_reg_o == '0)
    else $error("store or branch with a destination register");

endmodule

// ===== hw/rtl/rvdec_decode.sv =====
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational RV32I decode: kind, register numbers and immediate.
// ----------------------------------------------------------------------------
module rvdec_decode import rvdec_pkg::*; (
  input  logic [InstrWidth-1:0] instr_i,
  output decode_t               dec_o
);

  logic [6:0]            op;
  logic [2:0]            f3;
  logic [6:0]            f7;
  logic [RegWidth-1:0]   rd;
  logic [RegWidth-1:0]   rs1;
  logic [RegWidth-1:0]   rs2;
  logic [InstrWidth-1:0] imm_i;
  logic [InstrWidth-1:0] imm_s;
  logic [InstrWidth-1:0] imm_b;
  logic [InstrWidth-1:0] imm_j;
  logic [InstrWidth-1:0] imm_u;

  // Field extraction and immediate formats
  assign op    = instr_i[6:0];
  assign rd    = instr_i[11:7];
  assign f3    = instr_i[14:12];
  assign rs1   = instr_i[19:15];
  assign rs2   = instr_i[24:20];
  assign f7    = instr_i[31:25];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign imm_u = instr_i & UpperMask;

  // Opcode / funct decode; anything not matched stays unknown with zero fields
  always_comb begin
    decode_t d;
    d = '{kind: KIND_UNKNOWN, rd: '0, rs1: '0, rs2: '0, imm: '0};

    if (instr_i == HaltWord) begin
      d.kind = KIND_HALT;
    end else begin
      case (op)
        OpR: begin
          if (f7 == Funct7Zero) begin
            case (f3)
              3'd0:    d.kind = KIND_ADD;
              3'd1:    d.kind = KIND_SLL;
              3'd2:    d.kind = KIND_SLT;
              3'd3:    d.kind = KIND_SLTU;
              3'd4:    d.kind = KIND_XOR;
              3'd5:    d.kind = KIND_SRL;
              3'd6:    d.kind = KIND_OR;
              default: d.kind = KIND_AND;
            endcase
          end else if (f7 == Funct7Alt && f3 == 3'd0) begin
            d.kind = KIND_SUB;
          end else if (f7 == Funct7Alt && f3 == 3'd5) begin
            d.kind = KIND_SRA;
          end
          if (d.kind != KIND_UNKNOWN) begin
            d.rd  = rd;
            d.rs1 = rs1;
            d.rs2 = rs2;
          end
        end
        OpImm: begin
          case (f3)
            3'd0:    d.kind = KIND_ADDI;
            3'd1:    d.kind = (f7 == Funct7Zero) ? KIND_SLLI : KIND_UNKNOWN;
            3'd2:    d.kind = KIND_SLTI;
            3'd3:    d.kind = KIND_SLTIU;
            3'd4:    d.kind = KIND_XORI;
            3'd5: begin
              if (f7 == Funct7Zero)     d.kind = KIND_SRLI;
              else if (f7 == Funct7Alt) d.kind = KIND_SRAI;
            end
            3'd6:    d.kind = KIND_ORI;
            default: d.kind = KIND_ANDI;
          endcase
          if (d.kind != KIND_UNKNOWN) begin
            d.rd  = rd;
            d.rs1 = rs1;
            d.imm = imm_i;
          end
        end
        OpLoad: begin
          case (f3)
            3'd0:    d.kind = KIND_LB;
            3'd1:    d.kind = KIND_LH;
            3'd2:    d.kind = KIND_LW;
            3'd4:    d.kind = KIND_LBU;
            3'd5:    d.kind = KIND_LHU;
            default: d.kind = KIND_UNKNOWN;
          endcase
          if (d.kind != KIND_UNKNOWN) begin
            d.rd  = rd;
            d.rs1 = rs1;
            d.imm = imm_i;
          end
        end
        OpStore: begin
          case (f3)
            3'd0:    d.kind = KIND_SB;
            3'd1:    d.kind = KIND_SH;
            3'd2:    d.kind = KIND_SW;
            default: d.kind = KIND_UNKNOWN;
          endcase
          if (d.kind != KIND_UNKNOWN) begin
            d.rs1 = rs1;
            d.rs2 = rs2;
            d.imm = imm_s;
          end
        end
        OpBranch: begin
          case (f3)
            3'd0:    d.kind = KIND_BEQ;
            3'd1:    d.kind = KIND_BNE;
            3'd4:    d.kind = KIND_BLT;
            3'd5:    d.kind = KIND_BGE;
            3'd6:    d.kind = KIND_BLTU;
            3'd7:    d.kind = KIND_BGEU;
            default: d.kind = KIND_UNKNOWN;
          endcase
          if (d.kind != KIND_UNKNOWN) begin
            d.rs1 = rs1;
            d.rs2 = rs2;
            d.imm = imm_b;
          end
        end
        OpJal: begin
          d.kind = KIND_JAL;
          d.rd   = rd;
          d.imm  = imm_j;
        end
        OpJalr: begin
          if (f3 == 3'd0) begin
            d.kind = KIND_JALR;
            d.rd   = rd;
            d.rs1  = rs1;
            d.imm  = imm_i;
          end
        end
        OpAuipc: begin
          d.kind = KIND_AUIPC;
          d.rd   = rd;
          d.imm  = imm_u;
        end
        OpLui: begin
          d.kind = KIND_LUI;
          d.rd   = rd;
          d.imm  = imm_u;
        end
        OpSystem: begin
          // immediate 0 is ECALL, 1 is EBREAK; rd and rs1 bits are ignored
          if (f3 == 3'd0 && instr_i[31:20] == 12'd0)      d.kind = KIND_ECALL;
          else if (f3 == 3'd0 && instr_i[31:20] == 12'd1) d.kind = KIND_EBREAK;
        end
        default: d.kind = KIND_UNKNOWN;
      endcase
    end

    dec_o = d;
  end

endmodule
